// ===== hw/rtl/b64u_pkg.sv =====
// b64u_pkg: shared types and the 6-bit to URL-safe alphabet mapping
// for the base64url stream encoder. No dependencies.
package b64u_pkg;

  localparam int unsigned SymW  = 6;
  localparam int unsigned CharW = 8;

  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldTwo  = 2'd1;
  localparam logic [1:0] HeldFour = 2'd2;

  // up to two characters produced by one item
  typedef struct packed {
    logic [1:0]       n;
    logic [CharW-1:0] c0;
    logic [CharW-1:0] c1;
    logic             e0;
    logic             e1;
  } grp_t;

  function automatic logic [CharW-1:0] sym(input logic [SymW-1:0] v);
    logic [CharW-1:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      sym = 8'd65 + w;
    else if (v < 6'd52) sym = 8'd97 + (w - 8'd26);
    else if (v < 6'd62) sym = 8'd48 + (w - 8'd52);
    else if (v == 6'd62) sym = 8'd45;
    else                sym = 8'd95;
  endfunction

endpackage

// ===== hw/rtl/b64u_enc_core.sv =====
// b64u_enc_core: splits one byte against the leftover bits into one or two
// characters and the next leftover state. Uses b64u_pkg.
module b64u_enc_core (
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic [3:0]  held_bits,
  input  logic [1:0]  held_count,
  output logic [3:0]  bits_next,
  output logic [1:0]  count_next,
  output b64u_pkg::grp_t grp
);

  logic [5:0] v0;
  logic [5:0] v1;
  logic [1:0] n;
  logic [3:0] bits_mid;
  logic [1:0] count_mid;

  always_comb begin
    v1 = 6'd0;
    case (held_count)
      b64u_pkg::HeldTwo: begin
        v0        = {held_bits[1:0], data_byte[7:4]};
        bits_mid  = data_byte[3:0];
        count_mid = b64u_pkg::HeldFour;
        n         = 2'd1;
      end
      b64u_pkg::HeldFour: begin
        v0        = {held_bits, data_byte[7:6]};
        v1        = data_byte[5:0];
        bits_mid  = 4'd0;
        count_mid = b64u_pkg::HeldNone;
        n         = 2'd2;
      end
      default: begin
        v0        = data_byte[7:2];
        bits_mid  = {2'b00, data_byte[1:0]};
        count_mid = b64u_pkg::HeldTwo;
        n         = 2'd1;
      end
    endcase

    bits_next  = bits_mid;
    count_next = count_mid;
    if (final_byte) begin
      if (count_mid == b64u_pkg::HeldTwo) begin
        v1 = {bits_mid[1:0], 4'b0000};
        n  = 2'd2;
      end else if (count_mid == b64u_pkg::HeldFour) begin
        v1 = {bits_mid, 2'b00};
        n  = 2'd2;
      end
      bits_next  = 4'd0;
      count_next = b64u_pkg::HeldNone;
    end

    grp.n  = n;
    grp.c0 = b64u_pkg::sym(v0);
    grp.c1 = b64u_pkg::sym(v1);
    grp.e0 = final_byte && (n == 2'd1);
    grp.e1 = final_byte && (n == 2'd2);
  end

endmodule

// ===== hw/rtl/b64u_out_buf.sv =====
// b64u_out_buf: two-slot result register; loads a character group and
// presents one character per cycle while out_stall is low. Uses b64u_pkg.
module b64u_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  b64u_pkg::grp_t grp,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_char,
  output logic           run_end
);

  logic [1:0] cnt;
  logic [7:0] ch0;
  logic [7:0] ch1;
  logic       e0;
  logic       e1;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt == 2'd0) || ((cnt == 2'd1) && pop);
  assign out_char  = ch0;
  assign run_end   = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch0 <= grp.c0;
      ch1 <= grp.c1;
      e0  <= grp.e0;
      e1  <= grp.e1;
    end else if (pop) begin
      ch0 <= ch1;
      e0  <= e1;
    end
  end

endmodule

// ===== hw/rtl/base64url_stream_encoder.sv =====
// base64url_stream_encoder: unpadded base64url encoder, one byte per item.
// Depends on b64u_pkg, b64u_enc_core and b64u_out_buf.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  data_byte[7:0], final_byte
//   out      out_valid / out_stall out_char[7:0], run_end
//
// A byte is registered in the input register, then loads the two-slot
// result register with one or two characters when that has room. The
// result register sends one character a cycle while out_stall is low,
// so a byte that makes two characters holds back the next byte.
// Synchronous reset clears the leftover bits and all valid flags.
// in_stall rises only while the input register is full and cannot load.
module base64url_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_end
);

  logic           ir_valid;
  logic [7:0]     ir_byte;
  logic           ir_final;
  logic [3:0]     leftover_bits;
  logic [1:0]     leftover_count;
  logic [3:0]     bits_next;
  logic [1:0]     count_next;
  logic           room;
  logic           load;
  logic           accept;
  b64u_pkg::grp_t grp;

  assign load     = ir_valid && room;
  assign in_stall = ir_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (accept) begin
      ir_valid <= 1'b1;
    end else if (load) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_byte  <= data_byte;
      ir_final <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= 4'd0;
      leftover_count <= b64u_pkg::HeldNone;
    end else if (load) begin
      leftover_bits  <= bits_next;
      leftover_count <= count_next;
    end
  end

  b64u_enc_core u_core (
    .data_byte  (ir_byte),
    .final_byte (ir_final),
    .held_bits  (leftover_bits),
    .held_count (leftover_count),
    .bits_next  (bits_next),
    .count_next (count_next),
    .grp        (grp)
  );

  b64u_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .grp       (grp),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .run_end   (run_end)
  );

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    leftover_count != 2'd3)
    else $error("leftover count reached three");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (load && ir_final) |=> (leftover_count == b64u_pkg::HeldNone))
    else $error("final byte did not clear leftover state");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (ir_valid && out_valid))
    else $error("input stalled with no item held");

  a_load_full_group: assert property (@(posedge clk) disable iff (rst)
    (load && leftover_count == b64u_pkg::HeldFour) |-> (grp.n == 2'd2))
    else $error("four held bits did not yield two characters");

endmodule
